/* design/dlc_pkg.sv */
// Shared constants for the door lock controller: field widths, register
// indexes and reset values, reply, motor, action and menu codes.
// No dependencies.
`default_nettype none

package dlc_pkg;

   // Default sizes
   localparam int DLC_PASS_LEN   = 5;
   localparam int DLC_TICK_WIDTH = 16;

   // Configuration port
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int ATTEMPT_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNLOCK_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_TICKS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ATTEMPTS = 2'd3;

   localparam logic [CSR_DATA_W-1:0] UNLOCK_TICKS_RST = 16'd2;
   localparam logic [CSR_DATA_W-1:0] HOLD_TICKS_RST   = 16'd1;
   localparam logic [CSR_DATA_W-1:0] ALARM_TICKS_RST  = 16'd8;
   localparam logic [ATTEMPT_W-1:0]  MAX_ATTEMPTS_RST = 3'd3;

   // Input actions
   localparam logic [1:0] ACT_NEW_PAIR = 2'd0;
   localparam logic [1:0] ACT_ATTEMPT  = 2'd1;
   localparam logic [1:0] ACT_CHOICE   = 2'd2;
   localparam logic [1:0] ACT_TICK     = 2'd3;

   // Replies
   localparam logic [1:0] REPLY_NONE    = 2'd0;
   localparam logic [1:0] REPLY_CONFIRM = 2'd1;
   localparam logic [1:0] REPLY_WRONG   = 2'd2;
   localparam logic [1:0] REPLY_REPEAT  = 2'd3;

   // Motor drive
   localparam logic [1:0] MOTOR_STOP = 2'd0;
   localparam logic [1:0] MOTOR_CW   = 2'd1;
   localparam logic [1:0] MOTOR_CCW  = 2'd2;

   // Menu bytes
   localparam logic [7:0] CHOICE_OPEN   = 8'h2B;  // '+'
   localparam logic [7:0] CHOICE_CHANGE = 8'h2D;  // '-'

endpackage

`default_nettype wire

/* design/password_door_lock_controller.sv */
// Door lock controller: the result is registered, valid in the cycle after
// the input transfer. Throughput one item per cycle; the result register
// drains as the next item is taken; the input stalls only while a result is stalled.
// Synchronous active-high reset: setup mode, door idle, alarm off,
// failure count zero, registers at 2, 1, 8 and 3 ticks/attempts.
// Depends on dlc_pkg.
`default_nettype none

module password_door_lock_controller
   import dlc_pkg::*;
#(
   parameter int PASS_LEN   = DLC_PASS_LEN,
   parameter int TICK_WIDTH = DLC_TICK_WIDTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration
   input  wire logic                     csr_write,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [1:0]               req_action,
   input  wire logic [8*PASS_LEN-1:0]    req_entry_code,
   input  wire logic [8*PASS_LEN-1:0]    req_confirm_code,
   input  wire logic [7:0]               req_choice,
   // response channel
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [1:0]               rsp_reply,
   output      logic [1:0]               rsp_motor_drive,
   output      logic                     rsp_alarm_on,
   output      logic [1:0]               rsp_lock_mode
);

   localparam int CODE_W = 8 * PASS_LEN;

   typedef enum logic [1:0] {
      MODE_SETUP  = 2'd0,
      MODE_NORMAL = 2'd1,
      MODE_AWAIT  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_OPEN  = 2'd1,
      PH_HOLD  = 2'd2,
      PH_CLOSE = 2'd3
   } phase_type;

   // Configuration registers
   logic [CSR_DATA_W-1:0] unlock_ticks_ff;
   logic [CSR_DATA_W-1:0] hold_ticks_ff;
   logic [CSR_DATA_W-1:0] alarm_ticks_ff;
   logic [ATTEMPT_W-1:0]  max_attempts_ff;

   // Lock state
   mode_type              mode_ff, mode_in;
   logic [CODE_W-1:0]     stored_code_ff, stored_code_in;
   logic [ATTEMPT_W-1:0]  fail_count_ff, fail_count_in;
   phase_type             phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] door_timer_ff, door_timer_in;
   logic                  alarm_ff, alarm_in;
   logic [TICK_WIDTH-1:0] alarm_timer_ff, alarm_timer_in;

   // Result register
   logic                  rsp_valid_ff;
   logic [1:0]            reply_ff, reply_in;
   logic [1:0]            motor_ff, motor_in;
   logic                  buzzer_ff;
   logic [1:0]            lock_mode_ff;

   logic                  req_take;
   logic [ATTEMPT_W-1:0]  limit;
   logic [ATTEMPT_W-1:0]  fail_next;
   logic [TICK_WIDTH-1:0] door_dec;
   logic [TICK_WIDTH-1:0] alarm_dec;
   logic [TICK_WIDTH-1:0] unlock_load;
   logic [TICK_WIDTH-1:0] hold_load;
   logic [TICK_WIDTH-1:0] alarm_load;
   logic [CSR_DATA_W+TICK_WIDTH-1:0] unlock_ext;
   logic [CSR_DATA_W+TICK_WIDTH-1:0] hold_ext;
   logic [CSR_DATA_W+TICK_WIDTH-1:0] alarm_ext;

   // Take a new item unless a held result is still stalled
   assign req_take  = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply       = reply_ff;
   assign rsp_motor_drive = motor_ff;
   assign rsp_alarm_on    = buzzer_ff;
   assign rsp_lock_mode   = lock_mode_ff;

   // Fit tick registers to the timer width; a zero count loads as one
   assign unlock_ext  = {{TICK_WIDTH{1'b0}}, unlock_ticks_ff};
   assign hold_ext    = {{TICK_WIDTH{1'b0}}, hold_ticks_ff};
   assign alarm_ext   = {{TICK_WIDTH{1'b0}}, alarm_ticks_ff};
   assign unlock_load = (unlock_ext[TICK_WIDTH-1:0] == '0) ? TICK_WIDTH'(1)
                                                          : unlock_ext[TICK_WIDTH-1:0];
   assign hold_load   = (hold_ext[TICK_WIDTH-1:0] == '0) ? TICK_WIDTH'(1)
                                                        : hold_ext[TICK_WIDTH-1:0];
   assign alarm_load  = (alarm_ext[TICK_WIDTH-1:0] == '0) ? TICK_WIDTH'(1)
                                                         : alarm_ext[TICK_WIDTH-1:0];

   assign limit     = (max_attempts_ff == '0) ? ATTEMPT_W'(1) : max_attempts_ff;
   assign fail_next = fail_count_ff + ATTEMPT_W'(1);
   assign door_dec  = door_timer_ff - TICK_WIDTH'(door_timer_ff != '0);
   assign alarm_dec = alarm_timer_ff - TICK_WIDTH'(alarm_timer_ff != '0);

   // Next state and reply for the item at the input
   always_comb begin
      mode_in        = mode_ff;
      stored_code_in = stored_code_ff;
      fail_count_in  = fail_count_ff;
      phase_in       = phase_ff;
      door_timer_in  = door_timer_ff;
      alarm_in       = alarm_ff;
      alarm_timer_in = alarm_timer_ff;
      reply_in       = REPLY_NONE;

      unique case (req_action)
         ACT_NEW_PAIR: begin
            if (mode_ff == MODE_SETUP) begin
               if (req_entry_code == req_confirm_code) begin
                  stored_code_in = req_entry_code;
                  mode_in        = MODE_NORMAL;
                  reply_in       = REPLY_CONFIRM;
               end else begin
                  reply_in = REPLY_WRONG;
               end
            end
         end
         ACT_ATTEMPT: begin
            if (mode_ff == MODE_NORMAL) begin
               if (req_entry_code == stored_code_ff) begin
                  reply_in      = REPLY_CONFIRM;
                  fail_count_in = '0;
                  mode_in       = MODE_AWAIT;
               end else if (fail_next >= limit || fail_next == '0) begin
                  // lockout: sound the buzzer and restart the count
                  reply_in       = REPLY_WRONG;
                  alarm_in       = 1'b1;
                  alarm_timer_in = alarm_load;
                  fail_count_in  = '0;
               end else begin
                  reply_in      = REPLY_REPEAT;
                  fail_count_in = fail_next;
               end
            end
         end
         ACT_CHOICE: begin
            if (mode_ff == MODE_AWAIT) begin
               if (req_choice == CHOICE_OPEN) begin
                  phase_in      = PH_OPEN;
                  door_timer_in = unlock_load;
                  mode_in       = MODE_NORMAL;
               end else if (req_choice == CHOICE_CHANGE) begin
                  mode_in = MODE_SETUP;
               end else begin
                  mode_in = MODE_NORMAL;
               end
            end
         end
         ACT_TICK: begin
            // advance the door sequence
            if (phase_ff != PH_IDLE) begin
               door_timer_in = door_dec;
               if (door_dec == '0) begin
                  unique case (phase_ff)
                     PH_OPEN: begin
                        phase_in      = PH_HOLD;
                        door_timer_in = hold_load;
                     end
                     PH_HOLD: begin
                        phase_in      = PH_CLOSE;
                        door_timer_in = unlock_load;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
            // count down the alarm
            if (alarm_ff) begin
               alarm_timer_in = alarm_dec;
               if (alarm_dec == '0) begin
                  alarm_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // Motor follows the door phase after the item
   always_comb begin
      unique case (phase_in)
         PH_OPEN:  motor_in = MOTOR_CW;
         PH_CLOSE: motor_in = MOTOR_CCW;
         default:  motor_in = MOTOR_STOP;
      endcase
   end

   // Hold state, configuration and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_ticks_ff <= UNLOCK_TICKS_RST;
         hold_ticks_ff   <= HOLD_TICKS_RST;
         alarm_ticks_ff  <= ALARM_TICKS_RST;
         max_attempts_ff <= MAX_ATTEMPTS_RST;
         mode_ff         <= MODE_SETUP;
         fail_count_ff   <= '0;
         phase_ff        <= PH_IDLE;
         door_timer_ff   <= '0;
         alarm_ff        <= 1'b0;
         alarm_timer_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_UNLOCK_TICKS: unlock_ticks_ff <= csr_wdata;
               CSR_HOLD_TICKS:   hold_ticks_ff   <= csr_wdata;
               CSR_ALARM_TICKS:  alarm_ticks_ff  <= csr_wdata;
               CSR_MAX_ATTEMPTS: max_attempts_ff <= csr_wdata[ATTEMPT_W-1:0];
               default: ;
            endcase
         end

         if (req_take) begin
            mode_ff        <= mode_in;
            stored_code_ff <= stored_code_in;
            fail_count_ff  <= fail_count_in;
            phase_ff       <= phase_in;
            door_timer_ff  <= door_timer_in;
            alarm_ff       <= alarm_in;
            alarm_timer_ff <= alarm_timer_in;
            reply_ff       <= reply_in;
            motor_ff       <= motor_in;
            buzzer_ff      <= alarm_in;
            lock_mode_ff   <= mode_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            // drop the result once it has been taken
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire
